>>> hdl/serial_reply_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// Serial reply frame parser assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_REPLY_FRAME_PARSER_DEFINES_SVH
`define SERIAL_REPLY_FRAME_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRFP_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("srfp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRFP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("srfp: next-cycle check failed");

`endif

>>> hdl/srfp_pkg.sv
// ----------------------------------------------------------------------------
// Serial reply frame parser package
// Phase codes, status codes, register indexes and the structs passed
// between the parser's submodules.
// ----------------------------------------------------------------------------
package srfp_pkg;

    localparam logic [7:0] PREAMBLE_0 = 8'h55;
    localparam logic [7:0] PREAMBLE_1 = 8'hAA;

    localparam logic CFG_EXPECTED_CMD = 1'b0;
    localparam logic CFG_ACCEPT_LEN   = 1'b1;

    localparam logic [6:0] ACCEPT_LEN_RESET = 7'd64;

    typedef enum logic [7:0] {
        PH_PRE0  = 8'b0000_0001,
        PH_PRE1  = 8'b0000_0010,
        PH_CMD   = 8'b0000_0100,
        PH_RSVD  = 8'b0000_1000,
        PH_LENLO = 8'b0001_0000,
        PH_LENHI = 8'b0010_0000,
        PH_DATA  = 8'b0100_0000,
        PH_SUM   = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_CMD_MISMATCH = 2'd1,
        ST_TIMEOUT      = 2'd2
    } frame_status_t;

    typedef struct packed {
        logic [7:0] expected_cmd;
        logic [6:0] fwd_limit;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       link_timeout;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic          is_status;
        logic [7:0]    payload_byte;
        frame_status_t frame_status;
        logic          preamble_bad;
        logic          checksum_bad;
        logic [6:0]    delivered_count;
        logic [7:0]    received_cmd;
    } result_t;

endpackage

>>> hdl/serial_reply_frame_parser.sv
// ----------------------------------------------------------------------------
// Serial reply frame parser
// Takes one received byte per item, forwards payload bytes of matching
// frames up to the forwarding length and reports one status item at the end of every frame or on a link timeout.
// ----------------------------------------------------------------------------
// The parser accepts one byte every clock cycle as long as results are taken
// at the same pace. An accepted byte is held in an input register, the frame
// phase logic and 8-bit checksum add act on it from that register, and any
// result it causes is written into the output register and shown on the m_
// side from there. A result waiting on a stalled consumer stops acceptance
// only once the input register is also full. Configuration writes are always
// ready and take effect in the next cycle.
`include "serial_reply_frame_parser_defines.svh"

module serial_reply_frame_parser #(
    parameter int MAX_ACCEPT = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_link_timeout,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_status,
    output logic [7:0] m_payload_byte,
    output logic [1:0] m_frame_status,
    output logic       m_preamble_bad,
    output logic       m_checksum_bad,
    output logic [6:0] m_delivered_count,
    output logic [7:0] m_received_cmd,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    srfp_pkg::item_t   item;
    srfp_pkg::cfg_t    cfg;
    srfp_pkg::result_t res;
    logic              advance;
    logic              res_load;
    logic              can_take;

    assign advance = item.valid && can_take;

    srfp_in_stage u_in_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_link_timeout (s_link_timeout),
        .advance        (advance),
        .item           (item)
    );

    srfp_cfg #(
        .MAX_ACCEPT (MAX_ACCEPT)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    srfp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (item),
        .cfg      (cfg),
        .res_load (res_load),
        .res      (res)
    );

    srfp_out_reg u_out_reg (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .load              (res_load),
        .res               (res),
        .can_take          (can_take),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_is_status       (m_is_status),
        .m_payload_byte    (m_payload_byte),
        .m_frame_status    (m_frame_status),
        .m_preamble_bad    (m_preamble_bad),
        .m_checksum_bad    (m_checksum_bad),
        .m_delivered_count (m_delivered_count),
        .m_received_cmd    (m_received_cmd)
    );

    // Payload items carry nothing but the byte.
    `SRFP_ASSERT_IMPL(a_payload_clean, m_valid && !m_is_status, (m_frame_status == srfp_pkg::ST_OK) && (m_delivered_count == 7'd0) && !m_checksum_bad && !m_preamble_bad && (m_received_cmd == 8'd0))
    // A mismatch or timeout never reports forwarded bytes.
    `SRFP_ASSERT_IMPL(a_error_no_count, m_valid && m_is_status && (m_frame_status != srfp_pkg::ST_OK), m_delivered_count == 7'd0)
    `SRFP_ASSERT_IMPL(a_count_limit, m_valid, int'(m_delivered_count) <= MAX_ACCEPT)
    // A produced result must land in the output register.
    `SRFP_ASSERT_NEXT(a_result_lands, res_load, m_valid)

endmodule

>>> hdl/srfp_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers one received item; the stage refills in the same cycle it drains.
// ----------------------------------------------------------------------------
module srfp_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_rx_byte,
    input  logic            s_link_timeout,
    input  logic            advance,
    output srfp_pkg::item_t item
);

    logic       valid_reg;
    logic [7:0] rx_byte_reg;
    logic       link_timeout_reg;

    assign s_ready = !valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            rx_byte_reg      <= s_rx_byte;
            link_timeout_reg <= s_link_timeout;
        end
    end

    assign item.valid        = valid_reg;
    assign item.link_timeout = link_timeout_reg;
    assign item.rx_byte      = rx_byte_reg;

endmodule

>>> hdl/srfp_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the expected command and the forwarding length, and clamps the
// length to the build-time maximum.
// ----------------------------------------------------------------------------
module srfp_cfg #(
    parameter int MAX_ACCEPT = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [7:0]     cfg_data,
    output srfp_pkg::cfg_t cfg
);

    localparam logic [15:0] MAX_ACCEPT_W = 16'(MAX_ACCEPT);

    logic [7:0] expected_cmd_reg;
    logic [6:0] accept_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_cmd_reg <= 8'd0;
            accept_len_reg   <= srfp_pkg::ACCEPT_LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                srfp_pkg::CFG_EXPECTED_CMD: begin
                    expected_cmd_reg <= cfg_data;
                end
                srfp_pkg::CFG_ACCEPT_LEN: begin
                    accept_len_reg <= cfg_data[6:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg.expected_cmd = expected_cmd_reg;
    assign cfg.fwd_limit    = ({9'd0, accept_len_reg} > MAX_ACCEPT_W) ?
                              MAX_ACCEPT_W[6:0] : accept_len_reg;

endmodule

>>> hdl/srfp_parser.sv
// ----------------------------------------------------------------------------
// Frame parser
// Frame phase state and running checksum; decides per byte whether a
// payload or status result is produced.
// ----------------------------------------------------------------------------
module srfp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  srfp_pkg::item_t   item,
    input  srfp_pkg::cfg_t    cfg,
    output logic              res_load,
    output srfp_pkg::result_t res
);

    srfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       running_sum_reg, running_sum_next;
    logic [15:0]      frame_length_reg, frame_length_next;
    logic [15:0]      payload_index_reg, payload_index_next;
    logic             cmd_matched_reg, cmd_matched_next;
    logic             preamble_error_reg, preamble_error_next;
    logic [7:0]       seen_cmd_reg, seen_cmd_next;

    logic [7:0]  rx_byte;
    logic [7:0]  sum_add;
    logic [15:0] index_inc;
    logic [15:0] length_full;
    logic [15:0] limit_w;
    logic        has_result;
    logic        clear_frame;

    assign rx_byte     = item.rx_byte;
    assign sum_add     = running_sum_reg + rx_byte;
    assign index_inc   = payload_index_reg + 16'd1;
    assign length_full = {rx_byte, frame_length_reg[7:0]};
    assign limit_w     = {9'd0, cfg.fwd_limit};

    always_comb begin
        phase_next          = phase_reg;
        running_sum_next    = running_sum_reg;
        frame_length_next   = frame_length_reg;
        payload_index_next  = payload_index_reg;
        cmd_matched_next    = cmd_matched_reg;
        preamble_error_next = preamble_error_reg;
        seen_cmd_next       = seen_cmd_reg;
        res                 = '0;
        has_result          = 1'b0;
        clear_frame         = 1'b0;

        if (item.link_timeout) begin
            // Abort reports what was seen so far of the frame.
            has_result       = 1'b1;
            res.is_status    = 1'b1;
            res.frame_status = srfp_pkg::ST_TIMEOUT;
            res.preamble_bad = preamble_error_reg;
            res.received_cmd = seen_cmd_reg;
            clear_frame      = 1'b1;
        end else begin
            unique case (phase_reg)
                srfp_pkg::PH_PRE0: begin
                    clear_frame = 1'b1;
                end
                srfp_pkg::PH_PRE1: begin
                    if (rx_byte != srfp_pkg::PREAMBLE_1) begin
                        preamble_error_next = 1'b1;
                    end
                    phase_next = srfp_pkg::PH_CMD;
                end
                srfp_pkg::PH_CMD: begin
                    seen_cmd_next    = rx_byte;
                    cmd_matched_next = (rx_byte == cfg.expected_cmd);
                    running_sum_next = sum_add;
                    phase_next       = srfp_pkg::PH_RSVD;
                end
                srfp_pkg::PH_RSVD: begin
                    running_sum_next = sum_add;
                    phase_next       = srfp_pkg::PH_LENLO;
                end
                srfp_pkg::PH_LENLO: begin
                    running_sum_next  = sum_add;
                    frame_length_next = {8'd0, rx_byte};
                    phase_next        = srfp_pkg::PH_LENHI;
                end
                srfp_pkg::PH_LENHI: begin
                    running_sum_next   = sum_add;
                    frame_length_next  = length_full;
                    payload_index_next = 16'd0;
                    phase_next = (length_full == 16'd0) ? srfp_pkg::PH_SUM : srfp_pkg::PH_DATA;
                end
                srfp_pkg::PH_DATA: begin
                    running_sum_next = sum_add;
                    if (cmd_matched_reg && (payload_index_reg < limit_w)) begin
                        has_result       = 1'b1;
                        res.payload_byte = rx_byte;
                    end
                    payload_index_next = index_inc;
                    if (index_inc >= frame_length_reg) begin
                        phase_next = srfp_pkg::PH_SUM;
                    end
                end
                srfp_pkg::PH_SUM: begin
                    has_result       = 1'b1;
                    res.is_status    = 1'b1;
                    res.preamble_bad = preamble_error_reg;
                    res.checksum_bad = (rx_byte != running_sum_reg);
                    res.received_cmd = seen_cmd_reg;
                    if (cmd_matched_reg) begin
                        res.frame_status    = srfp_pkg::ST_OK;
                        res.delivered_count = (frame_length_reg < limit_w) ?
                                              frame_length_reg[6:0] : cfg.fwd_limit;
                    end else begin
                        res.frame_status = srfp_pkg::ST_CMD_MISMATCH;
                    end
                    clear_frame = 1'b1;
                end
                default: begin
                    clear_frame = 1'b1;
                end
            endcase
        end

        if (clear_frame) begin
            phase_next          = srfp_pkg::PH_PRE0;
            running_sum_next    = 8'd0;
            frame_length_next   = 16'd0;
            payload_index_next  = 16'd0;
            cmd_matched_next    = 1'b0;
            preamble_error_next = 1'b0;
            seen_cmd_next       = 8'd0;
        end

        // The first preamble byte starts a fresh frame and is checked on top of it.
        if (!item.link_timeout && (phase_reg == srfp_pkg::PH_PRE0)) begin
            preamble_error_next = (rx_byte != srfp_pkg::PREAMBLE_0);
            phase_next          = srfp_pkg::PH_PRE1;
        end
    end

    assign res_load = advance && has_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= srfp_pkg::PH_PRE0;
            running_sum_reg    <= 8'd0;
            frame_length_reg   <= 16'd0;
            payload_index_reg  <= 16'd0;
            cmd_matched_reg    <= 1'b0;
            preamble_error_reg <= 1'b0;
            seen_cmd_reg       <= 8'd0;
        end else if (advance) begin
            phase_reg          <= phase_next;
            running_sum_reg    <= running_sum_next;
            frame_length_reg   <= frame_length_next;
            payload_index_reg  <= payload_index_next;
            cmd_matched_reg    <= cmd_matched_next;
            preamble_error_reg <= preamble_error_next;
            seen_cmd_reg       <= seen_cmd_next;
        end
    end

endmodule

>>> hdl/srfp_out_reg.sv
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module srfp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  srfp_pkg::result_t res,
    output logic              can_take,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_status,
    output logic [7:0]        m_payload_byte,
    output logic [1:0]        m_frame_status,
    output logic              m_preamble_bad,
    output logic              m_checksum_bad,
    output logic [6:0]        m_delivered_count,
    output logic [7:0]        m_received_cmd
);

    logic              valid_reg;
    srfp_pkg::result_t res_reg;

    assign can_take = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid           = valid_reg;
    assign m_is_status       = res_reg.is_status;
    assign m_payload_byte    = res_reg.payload_byte;
    assign m_frame_status    = res_reg.frame_status;
    assign m_preamble_bad    = res_reg.preamble_bad;
    assign m_checksum_bad    = res_reg.checksum_bad;
    assign m_delivered_count = res_reg.delivered_count;
    assign m_received_cmd    = res_reg.received_cmd;

endmodule
